@@ src/tde_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tde_pkg;

  localparam int unsigned MaxSamplesDef = 1024;
  // dividend bits of the restoring divider: |num| < 2**68, shifted by 8 or 12
  localparam int unsigned DivW    = 76;
  localparam int unsigned DivCntW = $clog2(DivW);
  localparam int unsigned NumW    = 68;
  localparam int unsigned DenW    = 49;

  localparam logic [1:0] KindFirst  = 2'd0;
  localparam logic [1:0] KindSecond = 2'd1;
  localparam logic [1:0] KindEquiv  = 2'd2;

  typedef struct packed {
    logic [15:0] volume;
    logic [15:0] ph_value;
    logic        final_sample;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        at_volume;
    logic signed [31:0] value;
    logic               fault;
    logic               run_end;
  } out_beat_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_LOAD1, OP_LOAD2, OP_SQB, OP_SQN, OP_T1, OP_T2,
    OP_HP, OP_DEN, OP_DIVINIT, OP_DIVSTEP, OP_FINISH, OP_EMIT, OP_EMITEQ, OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] kind;
    logic       run_end;
  } cmd_t;

  typedef struct packed {
    logic n_ge2;
    logic n_ge4;
    logic fin;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ src/tde_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tde_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire tde_pkg::stat_t stat_i,
  output tde_pkg::cmd_t      cmd_o,
  output logic               busy_o
);
  import tde_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_LOAD, S_SQB, S_SQN, S_T1, S_T2, S_HP, S_DEN,
    S_DIVI, S_DIVS, S_FIN, S_EMIT, S_EQ, S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cnt_d   = cnt_q;
    cmd_o   = '{op: OP_NONE, kind: KindFirst, run_end: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        pass_d = 1'b0;
        if (stat_i.n_ge2) state_d = S_LOAD;
        else if (stat_i.fin) state_d = S_EQ;
        else state_d = S_COMMIT;
      end
      S_LOAD: begin
        cmd_o.op = pass_q ? OP_LOAD2 : OP_LOAD1;
        state_d  = S_SQB;
      end
      S_SQB: begin cmd_o.op = OP_SQB; state_d = S_SQN; end
      S_SQN: begin cmd_o.op = OP_SQN; state_d = S_T1; end
      S_T1:  begin cmd_o.op = OP_T1;  state_d = S_T2; end
      S_T2:  begin cmd_o.op = OP_T2;  state_d = S_HP; end
      S_HP:  begin cmd_o.op = OP_HP;  state_d = S_DEN; end
      S_DEN: begin cmd_o.op = OP_DEN; state_d = S_DIVI; end
      S_DIVI: begin
        cmd_o.op = OP_DIVINIT;
        cnt_d    = DivCntW'(DivW - 1);
        state_d  = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.op = OP_DIVSTEP;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_FIN;
      end
      S_FIN: begin cmd_o.op = OP_FINISH; state_d = S_EMIT; end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op      = OP_EMIT;
          cmd_o.kind    = pass_q ? KindSecond : KindFirst;
          cmd_o.run_end = pass_q ? !stat_i.fin : (!stat_i.n_ge4 && !stat_i.fin);
          if (!pass_q && stat_i.n_ge4) begin
            pass_d  = 1'b1;
            state_d = S_LOAD;
          end else if (stat_i.fin) begin
            state_d = S_EQ;
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_EQ: begin
        if (stat_i.out_free) begin
          cmd_o.op      = OP_EMITEQ;
          cmd_o.kind    = KindEquiv;
          cmd_o.run_end = 1'b1;
          state_d       = S_COMMIT;
        end
      end
      S_COMMIT: begin cmd_o.op = OP_COMMIT; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ src/tde_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tde_dp #(
  parameter int unsigned MAX_SAMPLES = tde_pkg::MaxSamplesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tde_pkg::cmd_t     cmd_i,
  input  wire tde_pkg::in_beat_t in_data_i,
  input  wire logic              out_stall_i,
  output tde_pkg::stat_t         stat_o,
  output logic                   out_valid_o,
  output tde_pkg::out_beat_t     out_data_o
);
  import tde_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);

  // curve state
  logic [15:0]        vw0_q, vw1_q, vw2_q, ph0_q, ph1_q;
  logic signed [31:0] sl0_q, sl1_q, s_q, best_q;
  logic [15:0]        bvol_q;
  logic               have_q;
  logic [CntW-1:0]    cnt_q;
  in_beat_t           in_q;

  // derivative operands
  logic               sel_q, sh12_q;
  logic [15:0]        at_q, hb_mag_q, hn_mag_q;
  logic [16:0]        hs_mag_q;
  logic [32:0]        dyn_mag_q, dyb_mag_q;
  logic               dyn_neg_q, dyb_neg_q, dneg_q, dzero_q;
  logic [31:0]        sqb_q, sqn_q, hp_q;
  logic [64:0]        t1_q, t2_q;
  logic signed [NumW-1:0] num_q;
  logic [DenW-1:0]    den_q;

  // divider
  logic [DivW-1:0]    div_q;
  logic [DenW-1:0]    rem_q;
  logic [32:0]        quo_q;
  logic               big_q, nneg_q, nzero_q;
  logic signed [31:0] res_val_q;
  logic               res_flt_q;

  out_beat_t          out_q;
  logic               out_valid_q;

  // load stage operands
  logic signed [33:0] ya, yb, yc, dyn, dyb;
  logic signed [16:0] hb, hn;
  logic signed [17:0] hs;
  always_comb begin
    if (cmd_i.op == OP_LOAD2) begin
      ya = 34'(sl1_q); yb = 34'(sl0_q); yc = 34'(s_q);
      hb = $signed({1'b0, vw1_q}) - $signed({1'b0, vw2_q});
      hn = $signed({1'b0, vw0_q}) - $signed({1'b0, vw1_q});
    end else begin
      ya = $signed({18'd0, ph1_q}); yb = $signed({18'd0, ph0_q});
      yc = $signed({18'd0, in_q.ph_value});
      hb = $signed({1'b0, vw0_q}) - $signed({1'b0, vw1_q});
      hn = $signed({1'b0, in_q.volume}) - $signed({1'b0, vw0_q});
    end
    dyn = yc - yb;
    dyb = yb - ya;
    hs  = 18'(hb) + 18'(hn);
  end

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQB: begin mul_a = 33'(hb_mag_q); mul_b = 32'(hb_mag_q); end
      OP_SQN: begin mul_a = 33'(hn_mag_q); mul_b = 32'(hn_mag_q); end
      OP_T1:  begin mul_a = dyn_mag_q; mul_b = sqb_q; end
      OP_T2:  begin mul_a = dyb_mag_q; mul_b = sqn_q; end
      OP_HP:  begin mul_a = 33'(hb_mag_q); mul_b = 32'(hn_mag_q); end
      OP_DEN: begin mul_a = 33'(hs_mag_q); mul_b = hp_q; end
      default: ;
    endcase
    prod = 65'(mul_a) * 65'(mul_b);
  end

  // signed sum of the two terms
  logic signed [NumW-1:0] t1s, t2s;
  assign t1s = dyn_neg_q ? -$signed(NumW'(t1_q)) : $signed(NumW'(t1_q));
  assign t2s = dyb_neg_q ? -$signed(NumW'(t2_q)) : $signed(NumW'(t2_q));

  logic [NumW-1:0] nmag;
  assign nmag = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  // one restoring step
  logic [DenW:0] rs;
  logic          qbit;
  assign rs   = {rem_q, div_q[DivW-1]};
  assign qbit = (rs >= {1'b0, den_q});

  // final saturation
  logic               qneg;
  logic signed [31:0] fval;
  logic               fflt;
  always_comb begin
    qneg = (nneg_q ^ dneg_q) && ((quo_q != '0) || big_q);
    fflt = 1'b0;
    if (dzero_q) begin
      fflt = 1'b1;
      fval = nzero_q ? 32'sd0 : (nneg_q ? 32'sh80000000 : 32'sh7FFFFFFF);
    end else if (!qneg) begin
      fval = (big_q || quo_q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
    end else begin
      fval = (big_q || quo_q > 33'h080000000) ? 32'sh80000000
                                              : $signed(32'(-quo_q));
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: in_q <= in_data_i;
      OP_LOAD1, OP_LOAD2: begin
        sel_q     <= (cmd_i.op == OP_LOAD2);
        sh12_q    <= (cmd_i.op == OP_LOAD1);
        at_q      <= (cmd_i.op == OP_LOAD2) ? vw1_q : vw0_q;
        dyn_neg_q <= dyn[33];
        dyb_neg_q <= dyb[33];
        dyn_mag_q <= dyn[33] ? 33'(-dyn) : 33'(dyn);
        dyb_mag_q <= dyb[33] ? 33'(-dyb) : 33'(dyb);
        hb_mag_q  <= hb[16] ? 16'(-hb) : 16'(hb);
        hn_mag_q  <= hn[16] ? 16'(-hn) : 16'(hn);
        hs_mag_q  <= hs[17] ? 17'(-hs) : 17'(hs);
        dneg_q    <= hb[16] ^ hn[16] ^ hs[17];
        dzero_q   <= (hb == '0) || (hn == '0) || (hs == '0);
      end
      OP_SQB: sqb_q <= prod[31:0];
      OP_SQN: sqn_q <= prod[31:0];
      OP_T1:  t1_q  <= prod;
      OP_T2:  t2_q  <= prod;
      OP_HP: begin
        hp_q  <= prod[31:0];
        num_q <= t1s + t2s;
      end
      OP_DEN: den_q <= prod[DenW-1:0];
      OP_DIVINIT: begin
        nneg_q  <= num_q[NumW-1];
        nzero_q <= (num_q == '0);
        div_q   <= sh12_q ? DivW'({nmag, 12'd0}) : DivW'({nmag, 8'd0});
        rem_q   <= '0;
        quo_q   <= '0;
        big_q   <= 1'b0;
      end
      OP_DIVSTEP: begin
        div_q <= {div_q[DivW-2:0], 1'b0};
        rem_q <= qbit ? DenW'(rs - {1'b0, den_q}) : DenW'(rs);
        big_q <= big_q | quo_q[32];
        quo_q <= {quo_q[31:0], qbit};
      end
      OP_FINISH: begin
        res_val_q <= fval;
        res_flt_q <= fflt;
        if (!sel_q) s_q <= fval;
      end
      OP_EMIT: out_q <= '{kind: cmd_i.kind, at_volume: at_q, value: res_val_q,
                          fault: res_flt_q, run_end: cmd_i.run_end};
      OP_EMITEQ: out_q <= '{kind: cmd_i.kind, at_volume: have_q ? bvol_q : 16'd0,
                            value: 32'sd0, fault: !have_q, run_end: cmd_i.run_end};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw0_q <= '0; vw1_q <= '0; vw2_q <= '0;
      ph0_q <= '0; ph1_q <= '0;
      sl0_q <= '0; sl1_q <= '0;
      best_q <= '0; bvol_q <= '0; have_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_EMIT || cmd_i.op == OP_EMITEQ) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.op == OP_FINISH && !sel_q && (!have_q || fval > best_q)) begin
        best_q <= fval;
        bvol_q <= at_q;
        have_q <= 1'b1;
      end
      if (cmd_i.op == OP_COMMIT) begin
        if (in_q.final_sample) begin
          vw0_q <= '0; vw1_q <= '0; vw2_q <= '0;
          ph0_q <= '0; ph1_q <= '0;
          sl0_q <= '0; sl1_q <= '0;
          best_q <= '0; bvol_q <= '0; have_q <= 1'b0;
          cnt_q <= '0;
        end else begin
          vw2_q <= vw1_q; vw1_q <= vw0_q; vw0_q <= in_q.volume;
          ph1_q <= ph0_q; ph0_q <= in_q.ph_value;
          if (stat_o.n_ge2) begin
            sl1_q <= sl0_q;
            sl0_q <= s_q;
          end
          if (cnt_q < CntW'(MAX_SAMPLES)) cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.n_ge2    = (cnt_q >= CntW'(2));
  assign stat_o.n_ge4    = (cnt_q >= CntW'(4));
  assign stat_o.fin      = in_q.final_sample;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ src/titration_derivative_equivalence.sv @@
// Titration derivative and equivalence point
//
// in channel: one beat per titration sample (volume Q8.8, pH Q4.12,
// final_sample flag); in_stall_o stays high while a sample is being worked
// out channel: up to three beats per sample, in the order first derivative,
// second derivative, equivalence point; run_end marks the last beat of a sample
// work: each derivative takes the multiply steps on the one shared
// multiplier and then the 76-step restoring divider shared by both
// derivatives; a sample with no derivative skips both; an output stall
// adds to the time a sample takes; one sample at a time
// when the receiver stalls, the finished beat stays in the output register
// and the block waits before loading the next one; a new sample is taken
// while the last beat of the previous one still waits
// reset: clears the sample windows, the count and the peak search; a final
// sample brings the same state back so the next curve starts fresh
`timescale 1ns / 1ps
`default_nettype none
module titration_derivative_equivalence #(
  parameter int unsigned MAX_SAMPLES = tde_pkg::MaxSamplesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tde_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tde_pkg::out_beat_t      out_data_o
);
  import tde_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  // controller steps the shared multiplier and divider
  tde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // windows, arithmetic, peak search and output register
  tde_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // busy from the first cycle after a beat is taken
  assign in_stall_o = busy;

endmodule
`default_nettype wire

@@ src/tde_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tde_check (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire tde_pkg::out_beat_t out_data_o
);
  import tde_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second sample taken while busy");

  a_equiv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindEquiv |->
      out_data_o.run_end && out_data_o.value == 32'sd0)
    else $error("equivalence beat malformed");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind != 2'd3)
    else $error("unknown result kind");

endmodule

bind titration_derivative_equivalence tde_check u_tde_check (.*);
`default_nettype wire

@@ sim/titration_derivative_equivalence_tb.sv @@
`timescale 1ns / 1ps
module titration_derivative_equivalence_tb;
  import tde_pkg::*;

  // cycles without any accepted beat before the run is declared hung
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SampleCap  = 1024;
  localparam int unsigned TailCycles = 250;
  localparam int unsigned RandItems  = 320;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  titration_derivative_equivalence dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // curve tracker: own copy of the block's sample windows and peak search
  // ---------------------------------------------------------------------------
  logic [15:0]        vol_hist[4];
  logic [15:0]        ph_hist[2];
  logic signed [31:0] slope_hist[2];
  int unsigned        samples_seen;
  logic signed [31:0] peak_slope;
  logic [15:0]        peak_volume;
  logic               peak_valid;

  out_beat_t pending_beats[$];
  int unsigned err_count = 0;
  bit          hold_req  = 1'b0;

  task automatic clear_curve();
    vol_hist     = '{default: '0};
    ph_hist      = '{default: '0};
    slope_hist   = '{default: '0};
    samples_seen = 0;
    peak_slope   = '0;
    peak_volume  = '0;
    peak_valid   = 1'b0;
  endtask

  // step-weighted central difference over non-uniform steps, exact,
  // truncated toward zero to Q16.16 and saturated
  function automatic logic signed [31:0] central_slope(
    input longint y0, input longint y1, input longint y2,
    input longint hb, input longint hn, input int sh, output logic zero_den);
    logic signed [127:0] dyb, dyn, wb, wn, num;
    logic [127:0]        mag, den, quo;
    logic                nneg, dneg, qneg;
    longint              hb_abs, hn_abs, hs_abs;
    dyb = y1 - y0;
    dyn = y2 - y1;
    wb  = hb;
    wn  = hn;
    num = dyn * wb * wb + dyb * wn * wn;
    nneg = num[127];
    mag  = nneg ? -num : num;
    hb_abs = (hb < 0) ? -hb : hb;
    hn_abs = (hn < 0) ? -hn : hn;
    hs_abs = ((hb + hn) < 0) ? -(hb + hn) : (hb + hn);
    den  = hb_abs;
    den  = den * hn_abs;
    den  = den * hs_abs;
    dneg = ((hb < 0) != (hn < 0)) != ((hb + hn) < 0);
    zero_den = (den == 0);
    // zero denominator: saturate toward the numerator's sign
    if (zero_den) begin
      if (mag == 0) return 32'sd0;
      return nneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    mag  = mag << sh;
    quo  = mag / den;
    qneg = (nneg != dneg) && (quo != 0);
    if (!qneg) return (quo > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    if (quo > 128'h8000_0000) return 32'sh8000_0000;
    return -quo[31:0];
  endfunction

  // works out the beats one accepted sample causes and queues them
  task automatic track_sample(input in_beat_t s);
    out_beat_t          beats[$];
    out_beat_t          b;
    logic signed [31:0] s1, s2;
    logic               f;
    int unsigned        n;
    n = samples_seen;
    vol_hist[3] = vol_hist[2];
    vol_hist[2] = vol_hist[1];
    vol_hist[1] = vol_hist[0];
    vol_hist[0] = s.volume;
    if (n >= 2) begin
      s1 = central_slope(ph_hist[1], ph_hist[0], s.ph_value,
                         longint'(vol_hist[1]) - longint'(vol_hist[2]),
                         longint'(vol_hist[0]) - longint'(vol_hist[1]), 12, f);
      b = '{kind: KindFirst, at_volume: vol_hist[1], value: s1, fault: f, run_end: 1'b0};
      beats.push_back(b);
      // ties keep the earliest slope
      if (!peak_valid || s1 > peak_slope) begin
        peak_slope  = s1;
        peak_volume = vol_hist[1];
        peak_valid  = 1'b1;
      end
      if (n >= 4) begin
        s2 = central_slope(slope_hist[1], slope_hist[0], s1,
                           longint'(vol_hist[2]) - longint'(vol_hist[3]),
                           longint'(vol_hist[1]) - longint'(vol_hist[2]), 8, f);
        b = '{kind: KindSecond, at_volume: vol_hist[2], value: s2, fault: f,
              run_end: 1'b0};
        beats.push_back(b);
      end
      slope_hist[1] = slope_hist[0];
      slope_hist[0] = s1;
    end
    ph_hist[1] = ph_hist[0];
    ph_hist[0] = s.ph_value;
    if (samples_seen < SampleCap) samples_seen++;
    if (s.final_sample) begin
      // equivalence beat at the peak; with no slope yet, volume 0 with fault
      b = '{kind: KindEquiv, at_volume: peak_valid ? peak_volume : 16'd0, value: '0,
            fault: !peak_valid, run_end: 1'b0};
      beats.push_back(b);
      clear_curve();
    end
    if (beats.size() > 0) beats[beats.size() - 1].run_end = 1'b1;
    foreach (beats[i]) pending_beats.push_back(beats[i]);
  endtask

  // ---------------------------------------------------------------------------
  // sender: drives at the falling edge, bursts with random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;
  int unsigned items_sent = 0;

  task automatic send_sample(input logic [15:0] vol, input logic [15:0] ph,
                             input logic fin);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= '{volume: vol, ph_value: ph, final_sample: fin};
    do @(posedge clk_i); while (in_stall_o);
    track_sample(in_data_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sender stops until every queued beat has come back
  task automatic wait_drained();
    pause_sender();
    while (pending_beats.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, with an on-demand long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : stall_pattern
    static int unsigned mode_left = 0;
    static int unsigned mode = 0;
    static int unsigned hold_left = 0;
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (mode_left == 0) begin
      mode      = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 150);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ((mode_left % 7) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checker: compares each accepted beat with the oldest expected one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : beat_check
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, out_data_o);
        err_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_data_o.kind !== want.kind) begin
          $display("%0t: kind exp %0d got %0d", $time, want.kind, out_data_o.kind);
          err_count++;
        end
        if (out_data_o.at_volume !== want.at_volume) begin
          $display("%0t: at_volume exp %h got %h", $time, want.at_volume,
                   out_data_o.at_volume);
          err_count++;
        end
        if (out_data_o.value !== want.value) begin
          $display("%0t: value exp %h got %h", $time, want.value, out_data_o.value);
          err_count++;
        end
        if (out_data_o.fault !== want.fault) begin
          $display("%0t: fault exp %b got %b", $time, want.fault, out_data_o.fault);
          err_count++;
        end
        if (out_data_o.run_end !== want.run_end) begin
          $display("%0t: run_end exp %b got %b", $time, want.run_end,
                   out_data_o.run_end);
          err_count++;
        end
      end
    end
  end

  // watchdog: cycles in which neither channel moves a beat
  always @(posedge clk_i) begin : watchdog
    static int unsigned idle_cycles = 0;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // final sample before any slope exists, and right at the first slope
  task automatic test_short_curves();
    send_sample(16'h0100, 16'h1000, 1'b1);
    send_sample(16'h0100, 16'h1000, 1'b0);
    send_sample(16'h0200, 16'h2000, 1'b1);
    send_sample(16'h0100, 16'h1000, 1'b0);
    send_sample(16'h0180, 16'h1800, 1'b0);
    send_sample(16'h0200, 16'h3000, 1'b1);
  endtask

  // zero steps and opposite steps of equal size, extremes of every field,
  // and a full five-sample window ending in three beats
  task automatic test_extremes();
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b0);   // opposite equal steps
    send_sample(16'h0000, 16'hFFFF, 1'b0);   // zero step, positive numerator
    send_sample(16'h0000, 16'h0000, 1'b0);   // zero step, negative numerator
    send_sample(16'h0000, 16'h0000, 1'b1);   // zero step, zero numerator
    // unit steps with big pH swings
    send_sample(16'h0001, 16'h0000, 1'b0);
    send_sample(16'h0002, 16'hE000, 1'b0);
    send_sample(16'h0003, 16'h0000, 1'b0);
    send_sample(16'h0004, 16'hFFFF, 1'b0);
    send_sample(16'h0005, 16'h0000, 1'b1);
  endtask

  // equal slopes keep the earliest peak; volumes that run backwards
  task automatic test_ties_and_reversal();
    send_sample(16'h0100, 16'h1000, 1'b0);
    send_sample(16'h0200, 16'h2000, 1'b0);
    send_sample(16'h0300, 16'h3000, 1'b0);
    send_sample(16'h0400, 16'h4000, 1'b0);
    send_sample(16'h0380, 16'h3000, 1'b0);   // step backwards
    send_sample(16'h0500, 16'h5000, 1'b1);
  endtask

  // one curve with realistic content: steps mostly small, pH rising as an S
  task automatic send_curve(input int unsigned len);
    logic [15:0] vol, ph, jump_at;
    int unsigned pick;
    vol     = $urandom_range(0, 16'h0400);
    jump_at = $urandom_range(1, len);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      vol = $urandom();                      // noise
      else if (pick == 1) vol = vol;                             // zero step
      else if (pick == 2) vol = vol - $urandom_range(1, 64);     // backwards
      else                vol = vol + $urandom_range(1, 300);
      if ($urandom_range(0, 9) == 0) ph = $urandom();
      else if (i < jump_at) ph = $urandom_range(16'h1000, 16'h4000);
      else ph = $urandom_range(16'h9000, 16'hE000);
      send_sample(vol, ph, i == len - 1);
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_curve(10);
    wait_drained();
    send_curve(4);
  endtask

  task automatic test_random();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < RandItems) begin
      // some stretches run back-to-back with no sender gaps
      gaps_on = ($urandom_range(0, 3) != 0);
      send_curve($urandom_range(1, 14));
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_curve();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_short_curves();
    test_extremes();
    test_ties_and_reversal();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (err_count == 0 && pending_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (pending_beats.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
